[src/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

    localparam int ADDR_W    = 48;
    localparam int SEEN_W    = 32;
    localparam int CFG_W     = 64;
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic [7:0]           byte_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [SEEN_W-1:0]    seen_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Register indexes on the configuration channel
    localparam cfg_index_t CFG_PATTERN_LOW    = 3'd0;
    localparam cfg_index_t CFG_PATTERN_HIGH   = 3'd1;
    localparam cfg_index_t CFG_CARE_MASK      = 3'd2;
    localparam cfg_index_t CFG_PATTERN_LENGTH = 3'd3;
    localparam cfg_index_t CFG_REGION_BASE    = 3'd4;

    // Current search setup
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [PAT_BYTES-1:0]   care;
        len_t                   length;
        addr_t                  base;
    } cfg_t;

    // Compare outcome for the current window
    typedef struct packed {
        logic  hit;
        addr_t address;
    } match_t;

endpackage

[src/mbps_cfg.sv]
// Configuration register file for the masked byte pattern scanner.
module mbps_cfg
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  mbps_pkg::cfg_index_t      cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0] cfg_data,
    output mbps_pkg::cfg_t            cfg
);

    mbps_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Write the addressed register; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:    cfg_reg.pattern[63:0]   <= cfg_data;
                mbps_pkg::CFG_PATTERN_HIGH:   cfg_reg.pattern[127:64] <= cfg_data;
                mbps_pkg::CFG_CARE_MASK:      cfg_reg.care   <= cfg_data[mbps_pkg::PAT_BYTES-1:0];
                mbps_pkg::CFG_PATTERN_LENGTH: cfg_reg.length <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_REGION_BASE:    cfg_reg.base   <= cfg_data[mbps_pkg::ADDR_W-1:0];
                default:                      cfg_reg        <= cfg_reg;
            endcase
        end
    end

endmodule

[src/mbps_match.sv]
// Parallel masked compare of the byte window against the pattern.
module mbps_match
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic [MAX_PATTERN-1:0][7:0] window,
    input  mbps_pkg::seen_t             seen,
    input  mbps_pkg::cfg_t              cfg,
    output mbps_pkg::match_t            result
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CMP_N = (MAX_PATTERN < mbps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                               : mbps_pkg::PAT_BYTES;

    logic            len_ok;
    logic            bytes_ok;
    mbps_pkg::seen_t offset;

    // Length must be nonzero, fit the window and be covered by bytes seen
    assign len_ok = (cfg.length != '0) && (7'(cfg.length) <= 7'(MAX_PATTERN))
                    && (seen >= mbps_pkg::SEEN_W'(cfg.length));

    // Check each cared pattern byte against its aligned window byte
    always_comb
    begin
        logic [6:0] pos;
        bytes_ok = 1'b1;
        pos      = '0;
        for (int j = 0; j < CMP_N; j++)
        begin
            pos = 7'(cfg.length) - 7'(j) - 7'd1;
            if ((5'(j) < cfg.length) && cfg.care[j]
                && (window[pos[IDX_W-1:0]] != cfg.pattern[8*j +: 8]))
            begin
                bytes_ok = 1'b0;
            end
        end
    end

    // Match start is the count of bytes seen less the pattern length
    assign offset         = seen - mbps_pkg::SEEN_W'(cfg.length);
    assign result.hit     = len_ok && bytes_ok;
    assign result.address = cfg.base + mbps_pkg::ADDR_W'(offset);

endmodule

[src/masked_byte_pattern_scan.sv]
// Top level of the masked byte pattern scanner: window, region state and result register.
//
// Bytes of one region stream in on the slave side, one per transfer. Each byte is
// shifted into a window of MAX_PATTERN bytes and compared in the same cycle against
// the masked pattern; a result (match address with found set, or found clear when the
// region ends without a match) appears on the master side the cycle after the byte
// that caused it. Throughput is one byte per clock, and the scanner takes a byte in
// every cycle, except while an earlier result waits in the result register and the
// master side is not ready. After a match the rest of the region is consumed without
// results. Configuration is written through its own channel; the user must write it
// only while no scan is in flight, as the block itself does not enforce this.
module masked_byte_pattern_scan
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  mbps_pkg::cfg_index_t         cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]   cfg_data,
    // Byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // last_byte
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]  m_tdata,   // [47:0] match_address
    output logic [0:0]                   m_tuser    // [0] found
);

    mbps_pkg::cfg_t              cfg;
    mbps_pkg::match_t            match;
    logic [MAX_PATTERN-1:0][7:0] window_reg;
    logic [MAX_PATTERN-1:0][7:0] window_next;
    mbps_pkg::seen_t             seen_reg;
    mbps_pkg::seen_t             seen_next;
    logic                        done_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    mbps_pkg::addr_t             out_addr_reg;
    logic                        accept;
    logic                        res_valid;
    logic                        res_found;

    mbps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Take a byte whenever the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Shift the new byte in at the newest end of the window
    always_comb
    begin
        window_next[0] = s_tdata;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // Saturate the byte count
    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;

    mbps_match #(.MAX_PATTERN(MAX_PATTERN)) u_match
    (
        .window (window_next),
        .seen   (seen_next),
        .cfg    (cfg),
        .result (match)
    );

    // A result comes from a match, or from the region end without one
    assign res_found = !done_reg && match.hit;
    assign res_valid = accept && !done_reg && (match.hit || s_tlast);

    // Advance the window only while the region is still being searched
    always_ff @(posedge clk)
    begin
        if (accept && !done_reg)
        begin
            window_reg <= window_next;
        end
    end

    // Hold region state; clear it after the region's last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                seen_reg <= '0;
                done_reg <= 1'b0;
            end
            else if (!done_reg)
            begin
                seen_reg <= seen_next;
                done_reg <= match.hit;
            end
        end
    end

    // Result register: load on a new result, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_found_reg <= res_found;
            out_addr_reg  <= res_found ? match.address : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_addr_reg;
    assign m_tuser[0] = out_found_reg;

    // A not-found result never carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero address");

    // Region state is clear after the last byte of a region
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> seen_reg == '0 && !done_reg)
        else $error("region state not cleared after last byte");

    // A finished region has seen at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> seen_reg != '0)
        else $error("region marked done with no bytes seen");

    // A match inside a region stops the search
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found && !s_tlast |=> done_reg && m_tvalid)
        else $error("match did not end the search");

endmodule

[tb/tb_masked_byte_pattern_scan.sv]
// Testbench for masked_byte_pattern_scan: directed and random regions checked against a predictor.
module tb_masked_byte_pattern_scan;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 800;
    localparam int HOLD_CYCLES  = 300;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    mbps_pkg::cfg_index_t          cfg_index = mbps_pkg::CFG_PATTERN_LOW;
    logic [mbps_pkg::CFG_W-1:0]    cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;   // [7:0] data_byte
    logic                          s_tlast   = 1'b0; // last_byte
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [mbps_pkg::ADDR_W-1:0]   m_tdata;          // [47:0] match_address
    logic [0:0]                    m_tuser;          // [0] found

    // Predictor copy of the search setup and region state
    logic [8*mbps_pkg::PAT_BYTES-1:0] search_pattern = '0;
    logic [mbps_pkg::PAT_BYTES-1:0]   search_care    = '0;
    mbps_pkg::len_t                   search_length  = '0;
    mbps_pkg::addr_t                  search_base    = '0;
    mbps_pkg::byte_t                  window [WINDOW] = '{default: '0};
    mbps_pkg::seen_t                  bytes_seen     = '0;
    bit                               region_done    = 1'b0;

    mbps_pkg::match_t expected_reports [$];
    int unsigned      scanned_count  = 0;
    int               mismatch_count = 0;

    // Stall controls for both sides
    bit   gaps_on      = 1'b1;
    logic rx_stalls_on = 1'b1;
    int   hold_len     = 0;
    int   hold_token   = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   idle_cycles  = 0;

    masked_byte_pattern_scan #(.MAX_PATTERN(WINDOW)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // Shift one byte into the window, compare, and return the report it causes
    function automatic bit predict_scan_byte(input mbps_pkg::byte_t value, input bit last,
                                             output mbps_pkg::match_t report);
        bit              has_report;
        bit              hit;
        int              len;
        mbps_pkg::seen_t offset;
        report     = '0;
        has_report = 1'b0;
        len        = search_length;
        if (!region_done)
        begin
            for (int k = WINDOW - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = value;
            if (bytes_seen != '1)
                bytes_seen = bytes_seen + 1'b1;
            hit = (len != 0) && (len <= WINDOW) && (bytes_seen >= mbps_pkg::seen_t'(len));
            if (hit)
            begin
                for (int j = 0; j < len; j++)
                    if (search_care[j] && window[len-1-j] != search_pattern[8*j +: 8])
                        hit = 1'b0;
            end
            if (hit)
            begin
                offset         = bytes_seen - mbps_pkg::seen_t'(len);
                report.hit     = 1'b1;
                report.address = search_base + mbps_pkg::addr_t'(offset);
                region_done    = 1'b1;
                has_report     = 1'b1;
            end
            else if (last)
                has_report = 1'b1;
        end
        // Start a fresh region after its final byte
        if (last)
        begin
            window      = '{default: '0};
            bytes_seen  = '0;
            region_done = 1'b0;
        end
        return has_report;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Write one register and lower the channel once the write is taken
    task automatic write_reg(input mbps_pkg::cfg_index_t index,
                             input logic [mbps_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            mbps_pkg::CFG_PATTERN_LOW:    search_pattern[63:0]   = value;
            mbps_pkg::CFG_PATTERN_HIGH:   search_pattern[127:64] = value;
            mbps_pkg::CFG_CARE_MASK:      search_care   = value[mbps_pkg::PAT_BYTES-1:0];
            mbps_pkg::CFG_PATTERN_LENGTH: search_length = value[mbps_pkg::LEN_W-1:0];
            mbps_pkg::CFG_REGION_BASE:    search_base   = value[mbps_pkg::ADDR_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one byte, with random gaps, and record the report it should cause
    task automatic send_byte(input mbps_pkg::byte_t value, input bit last);
        mbps_pkg::match_t report;
        while (gaps_on && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scanned_count++;
        if (predict_scan_byte(value, last, report))
            expected_reports.push_back(report);
    endtask

    // Hold the input until every expected report has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    // Drain, then allow for a byte still in flight that causes no report
    task automatic wait_idle();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    // Send one region: noise, a planted pattern, or a planted pattern with one bit broken
    task automatic send_region(input int n, input int style);
        mbps_pkg::byte_t bytes [];
        int              len;
        int              at;
        int              j;
        bit              from_pattern;
        bytes        = new[n];
        len          = search_length;
        from_pattern = $urandom_range(1);
        foreach (bytes[i])
            bytes[i] = from_pattern ? search_pattern[8*$urandom_range(15) +: 8]
                                    : mbps_pkg::byte_t'($urandom);
        if (style != 0 && len >= 1 && len <= WINDOW && len <= n)
        begin
            at = $urandom_range(n - len);
            for (j = 0; j < len; j++)
                if (search_care[j])
                    bytes[at+j] = search_pattern[8*j +: 8];
            if (style == 2)
            begin
                j = $urandom_range(len - 1);
                bytes[at+j] ^= mbps_pkg::byte_t'(1 << $urandom_range(7));
            end
        end
        foreach (bytes[i])
            send_byte(bytes[i], i == n - 1);
    endtask

    // Pick a random search setup, extremes included, and write every register
    task automatic pick_random_search();
        logic [63:0]     low_word;
        logic [63:0]     high_word;
        logic [15:0]     care;
        int              len;
        mbps_pkg::addr_t base;
        case ($urandom_range(7))
            0:       begin low_word = '0; high_word = '0; end
            1:       begin low_word = '1; high_word = '1; end
            default: begin low_word = {$urandom, $urandom}; high_word = {$urandom, $urandom}; end
        endcase
        case ($urandom_range(5))
            0:       care = '0;
            1:       care = '1;
            default: care = 16'($urandom);
        endcase
        case ($urandom_range(11))
            0:       len = 0;
            1:       len = $urandom_range(17, 31);
            2:       len = WINDOW;
            3:       len = 1;
            4:       len = $urandom_range(9, 15);
            default: len = $urandom_range(2, 8);
        endcase
        case ($urandom_range(5))
            0:       base = '0;
            1:       base = '1;
            default: base = mbps_pkg::addr_t'({$urandom, $urandom});
        endcase
        write_reg(mbps_pkg::CFG_PATTERN_LOW, low_word);
        write_reg(mbps_pkg::CFG_PATTERN_HIGH, high_word);
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'(care));
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'(len));
        write_reg(mbps_pkg::CFG_REGION_BASE, 64'(base));
    endtask

    // Reset setup has zero length: only the region end reports
    task automatic test_zero_length();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Full sixteen byte pattern completed by the region's final byte at the top address
    task automatic test_full_length_match();
        logic [8*mbps_pkg::PAT_BYTES-1:0] pattern;
        pattern = 128'h0F0E_0D0C_0B0A_0980_0706_0504_03A5_FF00;
        wait_idle();
        write_reg(mbps_pkg::CFG_PATTERN_LOW, pattern[63:0]);
        write_reg(mbps_pkg::CFG_PATTERN_HIGH, pattern[127:64]);
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'hFFFF);
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'(WINDOW));
        write_reg(mbps_pkg::CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF);
        for (int j = 0; j < WINDOW; j++)
            send_byte(pattern[8*j +: 8], j == WINDOW - 1);
    endtask

    // Wildcard byte, address wrapping past the top, and silence after the match
    task automatic test_wildcard_wrap_after_match();
        wait_idle();
        write_reg(mbps_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_00C3);
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'h0001);
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h11, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Length above the window never matches; a region shorter than the pattern ends empty
    task automatic test_oversize_and_short();
        wait_idle();
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'h0000);
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd31);
        send_byte(8'hC3, 1'b1);
        wait_idle();
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd2);
        send_byte(8'hC3, 1'b1);
    endtask

    // Every byte reports; hold the result side off so the block stalls its input
    task automatic test_output_backpressure();
        wait_idle();
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'h0000);
        write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd1);
        write_reg(mbps_pkg::CFG_REGION_BASE, 64'(mbps_pkg::addr_t'({$urandom, $urandom})));
        gaps_on = 1'b0;
        hold_len   <= HOLD_CYCLES;
        hold_token <= hold_token + 1;
        repeat (40)
            send_byte(mbps_pkg::byte_t'($urandom), 1'b1);
        wait_drained();
        gaps_on = 1'b1;
        repeat (20)
            send_byte(mbps_pkg::byte_t'($urandom), $urandom_range(1));
    endtask

    // Random setups with mostly well-formed regions; one stretch runs with no idling
    task automatic test_random_regions();
        int unsigned start;
        int          phase;
        int          n;
        int          style;
        start = scanned_count;
        phase = 0;
        while (scanned_count - start < RANDOM_BYTES)
        begin
            wait_idle();
            gaps_on = !(phase >= 5 && phase < 9);
            rx_stalls_on <= !(phase >= 5 && phase < 9);
            pick_random_search();
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(30, 60);
                else
                    n = $urandom_range(1, search_length + 12);
                style = $urandom_range(9);
                send_region(n, style < 2 ? 0 : (style < 4 ? 2 : 1));
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // Result side: random stalls, requested hold-offs, or always ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (rx_stalls_on)
            m_tready <= ($urandom_range(99) >= 18);
        else
            m_tready <= 1'b1;
    end

    // Compare each result transfer with the oldest expected report
    always @(posedge clk)
    begin
        mbps_pkg::match_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch($sformatf("unexpected result found=%0b address=%h",
                                          m_tuser[0], m_tdata));
            else
            begin
                want = expected_reports.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch($sformatf("found %0b, expected %0b", m_tuser[0], want.hit));
                if (m_tdata !== want.address)
                    report_mismatch($sformatf("match_address %h, expected %h",
                                              m_tdata, want.address));
            end
        end
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL masked_byte_pattern_scan");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_length();
        test_full_length_match();
        test_wildcard_wrap_after_match();
        test_oversize_and_short();
        test_output_backpressure();
        test_random_regions();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS masked_byte_pattern_scan");
        else
            $display("FAIL masked_byte_pattern_scan");
        $finish;
    end

endmodule

[files.f]
src/mbps_pkg.sv
src/mbps_cfg.sv
src/mbps_match.sv
src/masked_byte_pattern_scan.sv
tb/tb_masked_byte_pattern_scan.sv
